// ===== rtl/mwo_pkg.sv =====
// Shared constants and types for the mecanum wheel odometry block.
`default_nettype none

package mwo_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int WHEEL_COUNT       = 4;

    // field widths
    localparam int COUNT_W   = 32;
    localparam int SEC_W     = 32;
    localparam int NSEC_W    = 30;
    localparam int SPEED_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 96;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 21;
    localparam int RADIUS_W   = 20;
    localparam int HALF_W     = 21;
    localparam int GEAR_W     = 16;
    localparam int CPR_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_RADIUS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_LENGTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WIDTH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GEAR_RATIO   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNTS_REV   = 3'd4;

    localparam logic [RADIUS_W-1:0] RST_WHEEL_RADIUS = 20'd70000;
    localparam logic [HALF_W-1:0]   RST_HALF_LENGTH  = 21'd200000;
    localparam logic [HALF_W-1:0]   RST_HALF_WIDTH   = 21'd169000;
    localparam logic [GEAR_W-1:0]   RST_GEAR_RATIO   = 16'd1280;
    localparam logic [CPR_W-1:0]    RST_COUNTS_REV   = 16'd42;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STATUS_OK           = 2'd0;
    localparam t_status STATUS_FIRST        = 2'd1;
    localparam t_status STATUS_BAD_INTERVAL = 2'd2;

    // arithmetic constants
    localparam logic [18:0] PI_NUM     = 19'd314159;   // pi * 1e5
    localparam logic [29:0] NS_PER_S   = 30'd1000000000;
    localparam logic [4:0]  LIN_FACTOR = 5'd25;        // den side of vx, vy
    localparam logic [20:0] YAW_FACTOR = 21'd1280000;  // num side of yaw
    localparam int          LIN_SHIFT  = 5;            // num side of vx, vy: times 32

    // internal widths
    localparam int SUM_W = 34;   // sum of four signed 32-bit deltas
    localparam int MB_W  = 34;   // serial multiplier operand
    localparam int Q_W   = 33;   // quotient bits kept by the divider
    localparam int K_W   = 39;   // radius * PI_NUM
    localparam int DT_W  = 64;   // signed interval in ns

endpackage

`default_nettype wire

// ===== rtl/mecanum_wheel_odometry.sv =====
// Top level: mecanum wheel odometry with bit-serial multiplier and divider.
//
// Input channel s_axis: one transfer carries four encoder counts and a time
// stamp. Output channel m_axis: one transfer per input carries vx, vy and yaw
// rate (signed fixed point, FRAC_BITS fraction bits) with a status in tuser.
// Configuration: i_cfg_we writes register i_cfg_addr at the clock edge; write
// only while the block is idle.
//
// One sample is processed at a time. s_axis_tready is high while idle.
// First sample after reset: skips the arithmetic and goes to the output
// stage. A bad interval: ends after the interval product. A valid interval:
// runs the shift-add multiplier (one multiplier bit per cycle, ten products,
// each ending once its remaining bits are zero) and the restoring divider
// (33 quotient bits, one per cycle, three quotients).
//
// Reset (synchronous, active low) loads the default geometry, clears the
// previous counts and stamp and marks that no previous sample exists.
// If m_axis is stalled the finished result waits in the output register;
// the next sample is still accepted and computed, and only its own hand-off
// to the output register waits for the transfer of the earlier one.
`default_nettype none

module mecanum_wheel_odometry #(
    parameter int FRAC_BITS = mwo_pkg::DEFAULT_FRAC_BITS   // 8 .. 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [mwo_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [mwo_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // samples in
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: front_left_count, front_right_count, rear_left_count,
    //        rear_right_count, stamp_seconds, stamp_nanoseconds, 2 pad bits
    input  wire logic [mwo_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // results out
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: velocity_x, velocity_y, yaw_rate
    output logic [mwo_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // tuser: status
    output mwo_pkg::t_status                     m_axis_tuser
);

    import mwo_pkg::*;

    // Datapath width: numerators reach about 2^(92+FRAC_BITS), denominators
    // 2^116; the divider remainder stays below twice the denominator.
    localparam int WIDE_W = (FRAC_BITS + 94 > 118) ? FRAC_BITS + 94 : 118;
    localparam int CNT_W  = $clog2(Q_W);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DEND   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    // product sequence
    localparam logic [3:0] OP_DT   = 4'd0;  // |sec diff| * 1e9
    localparam logic [3:0] OP_GEAR = 4'd1;  // dt * gear ratio
    localparam logic [3:0] OP_CPR  = 4'd2;  // * counts per rev = base
    localparam logic [3:0] OP_LIN  = 4'd3;  // base * 25
    localparam logic [3:0] OP_YAW  = 4'd4;  // base * (l + w)
    localparam logic [3:0] OP_K    = 4'd5;  // radius * pi
    localparam logic [3:0] OP_NX   = 4'd6;  // k * |sum x|
    localparam logic [3:0] OP_NY   = 4'd7;  // k * |sum y|
    localparam logic [3:0] OP_NW1  = 4'd8;  // k * |sum yaw|
    localparam logic [3:0] OP_NW2  = 4'd9;  // * 1280000

    localparam logic [1:0] SEL_X   = 2'd0;
    localparam logic [1:0] SEL_Y   = 2'd1;
    localparam logic [1:0] SEL_YAW = 2'd2;

    // control
    logic [2:0]             r_state;
    logic [3:0]             r_op;
    logic [1:0]             r_div_sel;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_have_prev;
    logic                   r_out_valid;

    // configuration and sample history
    logic [RADIUS_W-1:0]    r_wheel_radius;
    logic [HALF_W-1:0]      r_half_length;
    logic [HALF_W-1:0]      r_half_width;
    logic [GEAR_W-1:0]      r_gear_ratio;
    logic [CPR_W-1:0]       r_counts_rev;
    logic [COUNT_W-1:0]     r_last_count [WHEEL_COUNT];
    logic [SEC_W-1:0]       r_last_sec;
    logic [NSEC_W-1:0]      r_last_nsec;

    // datapath
    logic                   r_sum_neg [3];
    logic [SUM_W-1:0]       r_sum_mag [3];
    logic                   r_sec_neg;
    logic [NSEC_W:0]        r_nsec_diff;
    logic [WIDE_W-1:0]      r_ma;
    logic [MB_W-1:0]        r_mb;
    logic [WIDE_W-1:0]      r_acc;
    logic [WIDE_W-1:0]      r_base;
    logic [WIDE_W-1:0]      r_den_lin;
    logic [WIDE_W-1:0]      r_den_yaw;
    logic [K_W-1:0]         r_k;
    logic [WIDE_W-1:0]      r_rem;
    logic [Q_W-1:0]         r_dlow;
    logic [Q_W-1:0]         r_q;
    logic                   r_big;
    logic                   r_div_neg;
    logic [SPEED_W-1:0]     r_res [3];
    t_status                r_res_status;
    logic [OUT_DATA_W-1:0]  r_out_data;
    t_status                r_out_status;

    // combinational
    logic                   in_fire;
    logic                   out_free;
    logic [COUNT_W-1:0]     in_count [WHEEL_COUNT];
    logic [SEC_W-1:0]       in_sec;
    logic [NSEC_W-1:0]      in_nsec;
    logic [SUM_W-1:0]       dext [WHEEL_COUNT];
    logic [SUM_W-1:0]       sum [3];
    logic [SEC_W:0]         sec_diff;
    logic [SEC_W-1:0]       sec_mag;
    logic [NSEC_W:0]        nsec_diff;
    logic [WIDE_W-1:0]      mul_acc_next;
    logic [DT_W-1:0]        dt_prod;
    logic [DT_W-1:0]        dt_signed;
    logic                   dt_pos;
    logic [HALF_W:0]        den_sum;
    logic [WIDE_W-1:0]      div_num;
    logic [WIDE_W-1:0]      div_den;
    logic [WIDE_W-1:0]      div_trial;
    logic                   div_ge;
    logic                   div_zero;
    logic                   div_over;
    logic [Q_W-1:0]         q_limit;
    logic                   q_big;
    logic [Q_W-1:0]         q_sat;
    logic [Q_W-1:0]         q_signed;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // ---- sample unpack, count deltas and wheel sums ----
    always_comb begin
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            in_count[i] = s_axis_tdata[i*COUNT_W +: COUNT_W];
            // delta wraps modulo 2^32, then reads as signed
            dext[i] = SUM_W'($signed(in_count[i] - r_last_count[i]));
        end
        in_sec  = s_axis_tdata[WHEEL_COUNT*COUNT_W +: SEC_W];
        in_nsec = s_axis_tdata[WHEEL_COUNT*COUNT_W + SEC_W +: NSEC_W];
        // wheel order: front-left, front-right, rear-left, rear-right
        sum[SEL_X]   = dext[0] + dext[1] + dext[2] + dext[3];
        sum[SEL_Y]   = dext[1] + dext[2] - dext[0] - dext[3];
        sum[SEL_YAW] = dext[1] + dext[3] - dext[0] - dext[2];
        sec_diff  = {1'b0, in_sec} - {1'b0, r_last_sec};
        sec_mag   = sec_diff[SEC_W] ? SEC_W'(~sec_diff + 1'b1) : sec_diff[SEC_W-1:0];
        nsec_diff = {1'b0, in_nsec} - {1'b0, r_last_nsec};
    end

    // ---- shift-add multiplier, interval check ----
    assign mul_acc_next = r_acc + (r_mb[0] ? r_ma : '0);
    assign dt_prod      = r_acc[DT_W-1:0];
    assign dt_signed    = (r_sec_neg ? (DT_W'(0) - dt_prod) : dt_prod)
                        + {{(DT_W-NSEC_W-1){r_nsec_diff[NSEC_W]}}, r_nsec_diff};
    assign dt_pos       = !dt_signed[DT_W-1] && (dt_signed != '0);
    assign den_sum      = {1'b0, r_half_length} + {1'b0, r_half_width};

    // ---- restoring divider ----
    always_comb begin
        if (r_op == OP_NW2) begin
            div_num = r_acc << FRAC_BITS;
        end else begin
            div_num = r_acc << (LIN_SHIFT + FRAC_BITS);
        end
    end

    assign div_den   = (r_div_sel == SEL_YAW) ? r_den_yaw : r_den_lin;
    assign div_trial = {r_rem[WIDE_W-2:0], r_dlow[Q_W-1]};
    assign div_ge    = (div_trial >= div_den);
    assign div_zero  = (r_rem == '0) && (r_dlow == '0);
    // high part already at or above the divisor: quotient needs more than Q_W bits
    assign div_over  = (r_rem >= div_den);

    // saturate to the signed output range
    assign q_limit  = r_div_neg ? (Q_W'(1) << (SPEED_W - 1)) : ((Q_W'(1) << (SPEED_W - 1)) - 1'b1);
    assign q_big    = r_big || (r_q > q_limit);
    assign q_sat    = q_big ? q_limit : r_q;
    assign q_signed = r_div_neg ? (Q_W'(0) - q_sat) : q_sat;

    // ---- control, configuration, history ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_op           <= OP_DT;
            r_div_sel      <= SEL_X;
            r_cnt          <= '0;
            r_have_prev    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_wheel_radius <= RST_WHEEL_RADIUS;
            r_half_length  <= RST_HALF_LENGTH;
            r_half_width   <= RST_HALF_WIDTH;
            r_gear_ratio   <= RST_GEAR_RATIO;
            r_counts_rev   <= RST_COUNTS_REV;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
                r_last_count[i] <= '0;
            end
            r_last_sec     <= '0;
            r_last_nsec    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WHEEL_RADIUS: r_wheel_radius <= i_cfg_wdata[RADIUS_W-1:0];
                    CFG_HALF_LENGTH:  r_half_length  <= i_cfg_wdata[HALF_W-1:0];
                    CFG_HALF_WIDTH:   r_half_width   <= i_cfg_wdata[HALF_W-1:0];
                    CFG_GEAR_RATIO:   r_gear_ratio   <= i_cfg_wdata[GEAR_W-1:0];
                    CFG_COUNTS_REV:   r_counts_rev   <= i_cfg_wdata[CPR_W-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        for (int i = 0; i < WHEEL_COUNT; i++) begin
                            r_last_count[i] <= in_count[i];
                        end
                        r_last_sec  <= in_sec;
                        r_last_nsec <= in_nsec;
                        r_have_prev <= 1'b1;
                        r_op        <= OP_DT;
                        r_state     <= r_have_prev ? S_MUL : S_FIN;
                    end
                end
                S_MUL: begin
                    if (r_mb == '0) begin
                        case (r_op)
                            OP_DT: begin
                                if (dt_pos) begin
                                    r_op <= OP_GEAR;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            OP_GEAR: r_op <= OP_CPR;
                            OP_CPR:  r_op <= OP_LIN;
                            OP_LIN:  r_op <= OP_YAW;
                            OP_YAW:  r_op <= OP_K;
                            OP_K:    r_op <= OP_NX;
                            OP_NX: begin
                                r_div_sel <= SEL_X;
                                r_state   <= S_DSTART;
                            end
                            OP_NY: begin
                                r_div_sel <= SEL_Y;
                                r_state   <= S_DSTART;
                            end
                            OP_NW1:  r_op <= OP_NW2;
                            OP_NW2: begin
                                r_div_sel <= SEL_YAW;
                                r_state   <= S_DSTART;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_DSTART: begin
                    r_cnt   <= '0;
                    r_state <= (div_zero || div_over) ? S_DEND : S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        r_state <= S_DEND;
                    end
                end
                S_DEND: begin
                    case (r_div_sel)
                        SEL_X: begin
                            r_op    <= OP_NY;
                            r_state <= S_MUL;
                        end
                        SEL_Y: begin
                            r_op    <= OP_NW1;
                            r_state <= S_MUL;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    for (int j = 0; j < 3; j++) begin
                        r_sum_neg[j] <= sum[j][SUM_W-1];
                        r_sum_mag[j] <= sum[j][SUM_W-1] ? (SUM_W'(0) - sum[j]) : sum[j];
                        r_res[j]     <= '0;
                    end
                    r_sec_neg    <= sec_diff[SEC_W];
                    r_nsec_diff  <= nsec_diff;
                    r_ma         <= WIDE_W'(sec_mag);
                    r_mb         <= MB_W'(NS_PER_S);
                    r_acc        <= '0;
                    r_res_status <= r_have_prev ? STATUS_OK : STATUS_FIRST;
                end
            end
            S_MUL: begin
                if (r_mb != '0) begin
                    r_acc <= mul_acc_next;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                end else begin
                    r_acc <= '0;
                    case (r_op)
                        OP_DT: begin
                            if (dt_pos) begin
                                r_ma <= WIDE_W'(dt_signed);
                                r_mb <= MB_W'(r_gear_ratio);
                            end else begin
                                r_res_status <= STATUS_BAD_INTERVAL;
                            end
                        end
                        OP_GEAR: begin
                            r_ma <= r_acc;
                            r_mb <= MB_W'(r_counts_rev);
                        end
                        OP_CPR: begin
                            r_base <= r_acc;
                            r_ma   <= r_acc;
                            r_mb   <= MB_W'(LIN_FACTOR);
                        end
                        OP_LIN: begin
                            r_den_lin <= r_acc;
                            r_ma      <= r_base;
                            r_mb      <= MB_W'(den_sum);
                        end
                        OP_YAW: begin
                            r_den_yaw <= r_acc;
                            r_ma      <= WIDE_W'(PI_NUM);
                            r_mb      <= MB_W'(r_wheel_radius);
                        end
                        OP_K: begin
                            r_k  <= r_acc[K_W-1:0];
                            r_ma <= WIDE_W'(r_acc[K_W-1:0]);
                            r_mb <= r_sum_mag[SEL_X];
                        end
                        OP_NW1: begin
                            r_ma <= r_acc;
                            r_mb <= MB_W'(YAW_FACTOR);
                        end
                        OP_NX, OP_NY, OP_NW2: begin
                            r_rem  <= div_num >> Q_W;
                            r_dlow <= div_num[Q_W-1:0];
                            case (r_op)
                                OP_NX:   r_div_neg <= r_sum_neg[SEL_X];
                                OP_NY:   r_div_neg <= r_sum_neg[SEL_Y];
                                default: r_div_neg <= r_sum_neg[SEL_YAW];
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_DSTART: begin
                r_q   <= '0;
                r_big <= !div_zero && div_over;
            end
            S_DIV: begin
                r_rem  <= div_ge ? (div_trial - div_den) : div_trial;
                r_dlow <= r_dlow << 1;
                r_q    <= {r_q[Q_W-2:0], div_ge};
            end
            S_DEND: begin
                case (r_div_sel)
                    SEL_X: begin
                        r_res[SEL_X] <= q_signed[SPEED_W-1:0];
                        r_ma         <= WIDE_W'(r_k);
                        r_mb         <= r_sum_mag[SEL_Y];
                        r_acc        <= '0;
                    end
                    SEL_Y: begin
                        r_res[SEL_Y] <= q_signed[SPEED_W-1:0];
                        r_ma         <= WIDE_W'(r_k);
                        r_mb         <= r_sum_mag[SEL_YAW];
                        r_acc        <= '0;
                    end
                    default: r_res[SEL_YAW] <= q_signed[SPEED_W-1:0];
                endcase
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_data   <= {r_res[SEL_YAW], r_res[SEL_Y], r_res[SEL_X]};
                    r_out_status <= r_res_status;
                end
            end
            default: ;
        endcase
    end

    // ---- checks ----
    // an accepted sample always leaves idle on the next cycle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("sample accepted but block stayed idle");

    // divider remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < div_den))
        else $error("divider remainder not below divisor");

    // first sample and bad interval carry zero speeds
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata == '0))
        else $error("non-ok status with nonzero speeds");

    // a result held for transfer is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== bench/mecanum_wheel_odometry_tb.sv =====
// Self-checking bench for the mecanum wheel odometry block: scoreboard class and top module.

typedef struct {
    logic [31:0] fl;     // front-left count
    logic [31:0] fr;     // front-right count
    logic [31:0] rl;     // rear-left count
    logic [31:0] rr;     // rear-right count
    logic [31:0] sec;    // stamp, whole seconds
    logic [29:0] nsec;   // stamp, nanoseconds part
} sample_t;

typedef struct {
    logic [31:0]      vx;
    logic [31:0]      vy;
    logic [31:0]      yaw;
    mwo_pkg::t_status status;
} twist_t;

class twist_scoreboard;
    localparam int FRAC_BITS = mwo_pkg::DEFAULT_FRAC_BITS;

    // register mirror
    logic [19:0] radius;
    logic [20:0] half_len;
    logic [20:0] half_wid;
    logic [15:0] gear;
    logic [15:0] cpr;

    // previous sample
    logic [31:0] prev_count [4];
    logic [31:0] prev_sec;
    logic [29:0] prev_nsec;
    bit          have_prev;

    twist_t due_twists [$];
    int     errors;
    int     accepted;
    int     checked;
    int     n_ok;
    int     n_first;
    int     n_bad;

    function new();
        radius   = mwo_pkg::RST_WHEEL_RADIUS;
        half_len = mwo_pkg::RST_HALF_LENGTH;
        half_wid = mwo_pkg::RST_HALF_WIDTH;
        gear     = mwo_pkg::RST_GEAR_RATIO;
        cpr      = mwo_pkg::RST_COUNTS_REV;
        foreach (prev_count[k]) prev_count[k] = '0;
        prev_sec  = '0;
        prev_nsec = '0;
        have_prev = 1'b0;
        errors    = 0;
        accepted  = 0;
        checked   = 0;
        n_ok      = 0;
        n_first   = 0;
        n_bad     = 0;
    endfunction

    task report(string what);
        if (errors < 100) $display("mismatch: %s", what);
        errors++;
    endtask

    function void set_reg(logic [2:0] idx, logic [20:0] val);
        case (idx)
            mwo_pkg::CFG_WHEEL_RADIUS: radius   = val[19:0];
            mwo_pkg::CFG_HALF_LENGTH:  half_len = val;
            mwo_pkg::CFG_HALF_WIDTH:   half_wid = val;
            mwo_pkg::CFG_GEAR_RATIO:   gear     = val[15:0];
            mwo_pkg::CFG_COUNTS_REV:   cpr      = val[15:0];
            default: ;
        endcase
    endfunction

    // sign(total) * floor(|total| * r * 314159 * extra * 2^FRAC / den), clamped to 32 bits
    function logic [31:0] body_rate(logic signed [35:0] total, logic [31:0] extra,
                                    logic [127:0] den);
        logic         neg;
        logic [35:0]  mag;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] lim;
        neg = total[35];
        mag = neg ? -total : total;
        num = {92'd0, mag};
        num = num * radius * 128'd314159 * extra;
        num = num << FRAC_BITS;
        if (num == '0) return 32'd0;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (den == '0) begin
            quo = lim;
        end else begin
            quo = num / den;
            if (quo > lim) quo = lim;
        end
        if (neg) quo = -quo;
        return quo[31:0];
    endfunction

    function void take_sample(sample_t s);
        logic [31:0]        now [4];
        logic [31:0]        diff;
        logic signed [35:0] d [4];
        longint             dt;
        logic [127:0]       base;
        logic [127:0]       den_lin;
        logic [127:0]       den_yaw;
        twist_t             r;
        bit                 first;
        now[0] = s.fl;
        now[1] = s.fr;
        now[2] = s.rl;
        now[3] = s.rr;
        first = !have_prev;
        dt = (longint'({32'd0, s.sec}) - longint'({32'd0, prev_sec})) * 64'sd1000000000
           + (longint'({34'd0, s.nsec}) - longint'({34'd0, prev_nsec}));
        for (int k = 0; k < 4; k++) begin
            diff = now[k] - prev_count[k];
            d[k] = {{4{diff[31]}}, diff};
            prev_count[k] = now[k];
        end
        prev_sec  = s.sec;
        prev_nsec = s.nsec;
        have_prev = 1'b1;

        r.vx     = '0;
        r.vy     = '0;
        r.yaw    = '0;
        r.status = mwo_pkg::STATUS_OK;
        if (first) begin
            r.status = mwo_pkg::STATUS_FIRST;
        end else if (dt <= 0) begin
            r.status = mwo_pkg::STATUS_BAD_INTERVAL;
        end else begin
            base    = {64'd0, dt};
            base    = base * gear * cpr;
            den_lin = base * 128'd25;
            den_yaw = base * (half_len + half_wid);
            r.vx  = body_rate(d[0] + d[1] + d[2] + d[3], 32'd32, den_lin);
            r.vy  = body_rate(-d[0] + d[1] + d[2] - d[3], 32'd32, den_lin);
            r.yaw = body_rate(-d[0] + d[1] - d[2] + d[3], 32'd1280000, den_yaw);
        end
        due_twists.push_back(r);
        accepted++;
    endfunction

    task check_twist(twist_t got);
        twist_t want;
        case (got.status)
            mwo_pkg::STATUS_OK:           n_ok++;
            mwo_pkg::STATUS_FIRST:        n_first++;
            mwo_pkg::STATUS_BAD_INTERVAL: n_bad++;
            default: ;
        endcase
        if (due_twists.size() == 0) begin
            report("result transfer with no sample outstanding");
        end else begin
            want = due_twists.pop_front();
            if (got.vx !== want.vx)
                report($sformatf("result %0d velocity_x %h, want %h", checked, got.vx, want.vx));
            if (got.vy !== want.vy)
                report($sformatf("result %0d velocity_y %h, want %h", checked, got.vy, want.vy));
            if (got.yaw !== want.yaw)
                report($sformatf("result %0d yaw_rate %h, want %h", checked, got.yaw, want.yaw));
            if (got.status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, got.status, want.status));
        end
        checked++;
    endtask

    function int outstanding();
        return due_twists.size();
    endfunction
endclass

module mecanum_wheel_odometry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // watchdog limit, with ample room for ~1850 items including gaps and stalls
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam longint NS_SEC  = 64'sd1000000000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_addr    = '0;
    logic [20:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: fl, fr, rl, rr counts, stamp seconds, stamp nanoseconds, 2 zero bits
    logic [mwo_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: velocity_x, velocity_y, yaw_rate
    logic [mwo_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: status
    mwo_pkg::t_status               m_axis_tuser;

    twist_scoreboard sb;
    sample_t         cur;              // last sample driven, base for the next one
    bit              send_gaps_on   = 1'b1;
    bit              recv_stalls_on = 1'b1;
    int              cycles         = 0;
    int              settings       = 1;   // reset geometry counts as the first

    mecanum_wheel_odometry u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    // watchdog
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timed out after %0d cycles, %0d results outstanding",
                 cycles, sb.outstanding());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitors. Both sample at the rising edge, before the block's own
    // nonblocking updates land, so they see the values of the transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sample_t s;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            s.fl   = s_axis_tdata[31:0];
            s.fr   = s_axis_tdata[63:32];
            s.rl   = s_axis_tdata[95:64];
            s.rr   = s_axis_tdata[127:96];
            s.sec  = s_axis_tdata[159:128];
            s.nsec = s_axis_tdata[189:160];
            sb.take_sample(s);
        end
    end

    always @(posedge i_clk) begin
        twist_t t;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t.vx     = m_axis_tdata[31:0];
            t.vy     = m_axis_tdata[63:32];
            t.yaw    = m_axis_tdata[95:64];
            t.status = m_axis_tuser;
            sb.check_twist(t);
        end
    end

    // ------------------------------------------------------------------
    // Result side: per result, either keep tready high or hold it low until
    // after tvalid shows up. Occasionally flips into a stretch
    // with no stalls at all.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            stall = recv_stalls_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
                while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
                repeat (stall - 1) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            if ($urandom_range(0, 39) == 0) recv_stalls_on = !recv_stalls_on;
        end
    end

    // ------------------------------------------------------------------
    // Sample side helpers
    // ------------------------------------------------------------------
    function automatic sample_t make_sample(logic [31:0] fl, logic [31:0] fr, logic [31:0] rl,
                                            logic [31:0] rr, logic [31:0] sec,
                                            logic [29:0] nsec);
        sample_t s;
        s.fl   = fl;
        s.fr   = fr;
        s.rl   = rl;
        s.rr   = rr;
        s.sec  = sec;
        s.nsec = nsec;
        return s;
    endfunction

    // next sample: counts moved by the given deltas, stamp moved forward by dt_ns
    // (seconds wrap at 32 bits, which shows up as a bad interval)
    function automatic sample_t step_from(sample_t base, logic [31:0] d0, logic [31:0] d1,
                                          logic [31:0] d2, logic [31:0] d3, longint dt_ns);
        sample_t s;
        longint  total;
        total  = longint'({32'd0, base.sec}) * NS_SEC + longint'({34'd0, base.nsec}) + dt_ns;
        s.fl   = base.fl + d0;
        s.fr   = base.fr + d1;
        s.rl   = base.rl + d2;
        s.rr   = base.rr + d3;
        s.sec  = 32'(total / NS_SEC);
        s.nsec = 30'(total % NS_SEC);
        return s;
    endfunction

    // mostly small encoder moves, some medium, some zero, a few anywhere in 32 bits
    function automatic logic [31:0] rand_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 6000) - 32'd3000;
            6, 7:             return $urandom_range(0, 2 * 1048576) - 32'd1048576;
            8:                return $urandom;
            default:          return 32'd0;
        endcase
    endfunction

    function automatic longint pick_interval();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return longint'($urandom_range(200_000, 40_000_000));
            7:                   return longint'($urandom_range(1, 2000));
            8:                   return longint'($urandom_range(1, 10)) * NS_SEC
                                      + longint'($urandom_range(0, 999_999_999));
            default:             return longint'($urandom)
                                      * longint'($urandom_range(1, 900_000_000));
        endcase
    endfunction

    function automatic sample_t next_sample();
        sample_t s;
        int      kind;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            // plausible motion: stamp moves forward, counts move a little
            s = step_from(cur, rand_delta(), rand_delta(), rand_delta(), rand_delta(),
                          pick_interval());
        end else if (kind < 85) begin
            // noise: every field anywhere in its width
            s = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, 30'($urandom));
        end else if (kind < 92) begin
            // repeated stamp
            s = step_from(cur, rand_delta(), rand_delta(), rand_delta(), rand_delta(), 0);
        end else begin
            // stamp stepping back (or only slightly forward)
            s      = step_from(cur, rand_delta(), rand_delta(), rand_delta(), rand_delta(), 0);
            s.sec  = cur.sec - $urandom_range(0, 2);
            s.nsec = 30'($urandom_range(0, 999_999_999));
        end
        return s;
    endfunction

    // One input transfer. tvalid is left high afterwards; it is only
    // lowered when a gap is drawn, so back-to-back items never see a
    // low/high pair within the same time step.
    task automatic send_sample(sample_t s);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, s.nsec, s.sec, s.rr, s.rl, s.fr, s.fl};
        cur = s;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        if ($urandom_range(0, 39) == 0) send_gaps_on = !send_gaps_on;
    endtask

    task automatic send_moves(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
                              logic [31:0] d3, longint dt_ns);
        send_sample(step_from(cur, d0, d1, d2, d3, dt_ns));
    endtask

    task automatic stream_samples(int n);
        repeat (n) send_sample(next_sample());
    endtask

    // block is idle once every result is back; a few spare cycles on top
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [20:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // all five registers in consecutive cycles, write enable dropped once at the end
    task automatic load_geometry(logic [20:0] r, logic [20:0] l, logic [20:0] w,
                                 logic [20:0] g, logic [20:0] c);
        write_reg(mwo_pkg::CFG_WHEEL_RADIUS, r);
        write_reg(mwo_pkg::CFG_HALF_LENGTH, l);
        write_reg(mwo_pkg::CFG_HALF_WIDTH, w);
        write_reg(mwo_pkg::CFG_GEAR_RATIO, g);
        write_reg(mwo_pkg::CFG_COUNTS_REV, c);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic load_random_geometry();
        load_geometry($urandom_range(1, 1_000_000), $urandom_range(0, 2_000_000),
                      $urandom_range(0, 2_000_000), $urandom_range(1, 65535),
                      $urandom_range(1, 65535));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        cur = make_sample('0, '0, '0, '0, '0, '0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset geometry
        send_sample(make_sample('0, '0, '0, '0, '0, '0));        // first sample after reset
        send_moves(100, 100, 100, 100, 0);                       // same stamp
        send_moves(50, 50, 50, 50, 10_000_000);                  // straight ahead
        send_sample(make_sample(cur.fl, cur.fr, cur.rl, cur.rr, 0, 5_000_000)); // stamp back
        send_moves(-80, 80, 80, -80, 20_000_000);                // pure strafe
        send_moves(-60, 60, -60, 60, 20_000_000);                // pure rotation
        send_moves(-300, -300, -300, -300, 7_000_000);           // reverse
        send_sample(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                3, 0));
        send_moves(1, 1, 1, 1, 1_000_000);                       // counts wrap past max
        send_moves(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        send_moves(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_moves(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_moves(0, 0, 0, 0, 50_000_000);                      // standing still
        send_sample(make_sample(cur.fl, cur.fr, cur.rl, cur.rr, cur.sec, 30'h3FFF_FFFF));
        send_sample(make_sample(cur.fl + 7, cur.fr - 7, cur.rl, cur.rr, cur.sec + 1, 0));
        send_sample(make_sample($urandom, $urandom, $urandom, $urandom,
                                32'hFFFF_FFFF, 999_999_999));    // largest stamp
        send_moves(1000, -1000, 500, -500, 10);                  // seconds wrap to zero
        send_moves(12345, 23456, -34567, 45678, 3_000_000);
        send_moves(1, 0, 0, 0, 1);                               // one count in 1 ns
        send_moves(0, 0, 0, -1, 1);
        send_moves(1, 1, 1, 1, 64'sd4000000000000000000);        // very long interval
        stream_samples(300);
        wait_for_results();

        // smallest geometry; l + w = 0 makes the yaw divisor zero
        load_geometry(1, 0, 0, 1, 1);
        stream_samples(150);
        wait_for_results();

        // largest geometry
        load_geometry(1_000_000, 2_000_000, 2_000_000, 65535, 65535);
        stream_samples(250);
        wait_for_results();

        load_random_geometry();
        stream_samples(250);
        wait_for_results();

        // raw 21-bit writes, bits above each register width get dropped
        load_geometry(21'($urandom), 21'($urandom), 21'($urandom), 21'($urandom),
                      21'($urandom));
        stream_samples(250);
        wait_for_results();

        // zero gear ratio: every speed divisor is zero
        load_geometry(70000, 200000, 169000, 0, 42);
        stream_samples(100);
        wait_for_results();

        // zero counts per revolution
        load_geometry($urandom_range(1, 1_000_000), 200000, 169000,
                      $urandom_range(1, 65535), 0);
        stream_samples(60);
        wait_for_results();

        load_random_geometry();
        stream_samples(440);
        wait_for_results();

        // let any stray result show up before closing
        repeat (400) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));

        $display("ran %0d samples over %0d register settings in %0d cycles",
                 sb.accepted, settings, cycles);
        $display("results seen: %0d ok, %0d first sample, %0d bad interval; %0d mismatches",
                 sb.n_ok, sb.n_first, sb.n_bad, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
